// ----- rtl/xed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_pkg
// shared types, character codes and prefix patterns for the xml element
// delimiter
// ----------------------------------------------------------------------------
package xed_pkg;

   localparam int BRACKET_BITS_DEFAULT = 8;
   localparam int LINE_BITS_DEFAULT    = 32;

   localparam int OFFSET_BITS = 4;

   localparam logic [OFFSET_BITS-1:0] OFFSET_FIRST       = 4'd1;
   localparam logic [OFFSET_BITS-1:0] COMMENT_PREFIX_LEN = 4'd3;
   localparam logic [OFFSET_BITS-1:0] CDATA_PREFIX_LEN   = 4'd8;
   localparam logic [OFFSET_BITS-1:0] DOCTYPE_PREFIX_LEN = 4'd8;
   localparam logic [OFFSET_BITS-1:0] DOCTYPE_SEP_OFFSET = 4'd9;
   localparam logic [OFFSET_BITS-1:0] COMMENT_END_OFFSET = 4'd7;
   localparam logic [OFFSET_BITS-1:0] CDATA_END_OFFSET   = 4'd12;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX         = 4'd15;

   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // candidate bits of the prefix search
   localparam int CAND_COMMENT = 0;
   localparam int CAND_CDATA   = 1;
   localparam int CAND_DOCTYPE = 2;
   localparam logic [2:0] CAND_ALL = 3'b111;

   typedef enum logic [1:0] {
      CLASS_PLAIN   = 2'd0,
      CLASS_COMMENT = 2'd1,
      CLASS_CDATA   = 2'd2,
      CLASS_DOCTYPE = 2'd3
   } tag_class_type;

   typedef struct packed {
      logic [2:0]    alive;
      tag_class_type cls;
   } prefix_type;

   localparam prefix_type PREFIX_RESET = '{alive: CAND_ALL, cls: CLASS_PLAIN};

   function automatic logic [7:0] comment_char(input logic [OFFSET_BITS-1:0] k);
      logic [7:0] c;
      c = CHAR_DASH;
      if (k == OFFSET_FIRST) begin
         c = CHAR_BANG;
      end
      return c;
   endfunction

   // "![CDATA[" at offsets 1 to 8
   function automatic logic [7:0] cdata_char(input logic [OFFSET_BITS-1:0] k);
      logic [7:0] c;
      case (k)
         4'd1:    c = CHAR_BANG;
         4'd2:    c = CHAR_LBRACK;
         4'd3:    c = 8'h43;
         4'd4:    c = 8'h44;
         4'd5:    c = 8'h41;
         4'd6:    c = 8'h54;
         4'd7:    c = 8'h41;
         default: c = CHAR_LBRACK;
      endcase
      return c;
   endfunction

   // "!DOCTYPE" at offsets 1 to 8, upper case
   function automatic logic [7:0] doctype_char(input logic [OFFSET_BITS-1:0] k);
      logic [7:0] c;
      case (k)
         4'd1:    c = CHAR_BANG;
         4'd2:    c = 8'h44;
         4'd3:    c = 8'h4F;
         4'd4:    c = 8'h43;
         4'd5:    c = 8'h54;
         4'd6:    c = 8'h59;
         4'd7:    c = 8'h50;
         default: c = 8'h45;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         u = c - CASE_OFFSET;
      end
      return u;
   endfunction

   function automatic logic is_c_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_xml_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

// ----- rtl/xml_element_delimiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_element_delimiter
// Splits an XML byte stream into literal text and tags, one byte per
// transaction and one result per byte. A '<' in literal text opens a tag and
// reports the non-blank byte count of the literal it closes. Tags are classed
// from their prefix as plain, comment, CDATA or DOCTYPE (case-insensitive)
// and the byte that ends the tag is flagged; DOCTYPE tracks square-bracket
// depth, saturating at 2^BRACKET_BITS-1. Every LF advances a line counter of
// LINE_BITS bits that saturates at its maximum; the low 32 bits are reported.
// The tokenizer state and the result register are updated at the edge that
// accepts the byte, so a byte can be accepted every cycle unless req_stall is
// high, and its result is valid in the next cycle. The result register holds
// while rsp_stall is high, and req_stall is raised only when that register
// is full and stalled.
// ----------------------------------------------------------------------------
module xml_element_delimiter #(
   parameter int BRACKET_BITS = xed_pkg::BRACKET_BITS_DEFAULT,
   parameter int LINE_BITS    = xed_pkg::LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_inside_tag,
   output logic        rsp_tag_end,
   output logic [1:0]  rsp_tag_class,
   output logic        rsp_literal_end,
   output logic [15:0] rsp_literal_nonblank,
   output logic [31:0] rsp_line_number
);

   localparam int OB = xed_pkg::OFFSET_BITS;

   // tokenizer state
   logic                    tag_mode_ff, tag_mode_in;
   logic [OB-1:0]           tag_offset_ff, tag_offset_in;
   xed_pkg::prefix_type     prefix_ff, prefix_in;
   logic [7:0]              prev1_ff, prev1_in;     // last tag byte
   logic [7:0]              prev2_ff, prev2_in;     // the one before it
   logic [BRACKET_BITS-1:0] bracket_ff, bracket_in;
   logic [15:0]             nonblank_ff, nonblank_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        inside_ff, inside_in;
   logic        end_ff, end_in;
   logic [1:0]  class_ff, class_in;
   logic        lend_ff, lend_in;
   logic [15:0] lcount_ff, lcount_in;
   logic [31:0] line_out_ff;

   logic                   accept;
   logic                   ends;
   xed_pkg::prefix_type    prefix_upd;
   xed_pkg::tag_class_type cls;

   // result register frees up when empty or when its transaction is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   xed_prefix_classify u_classify (
      .offset      (tag_offset_ff),
      .data_byte   (req_data_byte),
      .prefix_cur  (prefix_ff),
      .prefix_next (prefix_upd)
   );

   assign cls = prefix_upd.cls;

   always_comb begin
      tag_mode_in   = tag_mode_ff;
      tag_offset_in = tag_offset_ff;
      prefix_in     = prefix_ff;
      prev1_in      = prev1_ff;
      prev2_in      = prev2_ff;
      bracket_in    = bracket_ff;
      nonblank_in   = nonblank_ff;
      line_in       = line_ff;
      inside_in     = 1'b0;
      end_in        = 1'b0;
      class_in      = 2'(xed_pkg::CLASS_PLAIN);
      lend_in       = 1'b0;
      lcount_in     = '0;
      ends          = 1'b0;

      if (!tag_mode_ff) begin
         if (req_data_byte == xed_pkg::CHAR_LT) begin
            // literal closes, tag opens with the '<' at offset 0
            inside_in     = 1'b1;
            lend_in       = (nonblank_ff != '0);
            lcount_in     = nonblank_ff;
            nonblank_in   = '0;
            tag_mode_in   = 1'b1;
            tag_offset_in = xed_pkg::OFFSET_FIRST;
            prefix_in     = xed_pkg::PREFIX_RESET;
            prev1_in      = req_data_byte;
            prev2_in      = '0;
            bracket_in    = '0;
         end else if (!xed_pkg::is_xml_blank(req_data_byte) && nonblank_ff != '1) begin
            nonblank_in = nonblank_ff + 16'd1;
         end
      end else begin
         if (req_data_byte == xed_pkg::CHAR_GT) begin
            unique case (cls)
               xed_pkg::CLASS_PLAIN:   ends = 1'b1;
               xed_pkg::CLASS_COMMENT: ends = tag_offset_ff >= xed_pkg::COMMENT_END_OFFSET &&
                                              prev1_ff == xed_pkg::CHAR_DASH &&
                                              prev2_ff == xed_pkg::CHAR_DASH;
               xed_pkg::CLASS_CDATA:   ends = tag_offset_ff >= xed_pkg::CDATA_END_OFFSET &&
                                              prev1_ff == xed_pkg::CHAR_RBRACK &&
                                              prev2_ff == xed_pkg::CHAR_RBRACK;
               xed_pkg::CLASS_DOCTYPE: ends = (bracket_ff == '0);
               default:                ends = 1'b1;
            endcase
         end else if (cls == xed_pkg::CLASS_DOCTYPE) begin
            // internal subset depth, saturating at both ends
            if (req_data_byte == xed_pkg::CHAR_LBRACK && bracket_ff != '1) begin
               bracket_in = bracket_ff + 1'b1;
            end else if (req_data_byte == xed_pkg::CHAR_RBRACK && bracket_ff != '0) begin
               bracket_in = bracket_ff - 1'b1;
            end
         end

         inside_in = 1'b1;
         class_in  = 2'(cls);
         prefix_in = prefix_upd;
         prev2_in  = prev1_ff;
         prev1_in  = req_data_byte;
         if (tag_offset_ff != xed_pkg::OFFSET_MAX) begin
            tag_offset_in = tag_offset_ff + 1'b1;
         end

         if (ends) begin
            end_in        = 1'b1;
            tag_mode_in   = 1'b0;
            tag_offset_in = '0;
            prefix_in     = xed_pkg::PREFIX_RESET;
            prev1_in      = '0;
            prev2_in      = '0;
            bracket_in    = '0;
         end
      end

      // line counter runs in both modes
      if (req_data_byte == xed_pkg::CHAR_LF && line_ff != '1) begin
         line_in = line_ff + 1'b1;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_mode_ff   <= 1'b0;
         tag_offset_ff <= '0;
         prefix_ff     <= xed_pkg::PREFIX_RESET;
         prev1_ff      <= '0;
         prev2_ff      <= '0;
         bracket_ff    <= '0;
         nonblank_ff   <= '0;
         line_ff       <= LINE_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tag_mode_ff   <= tag_mode_in;
            tag_offset_ff <= tag_offset_in;
            prefix_ff     <= prefix_in;
            prev1_ff      <= prev1_in;
            prev2_ff      <= prev2_in;
            bracket_ff    <= bracket_in;
            nonblank_ff   <= nonblank_in;
            line_ff       <= line_in;
         end
      end
   end

   // payload of the result register, loaded with each accepted byte
   always_ff @(posedge clock) begin
      if (accept) begin
         inside_ff   <= inside_in;
         end_ff      <= end_in;
         class_ff    <= class_in;
         lend_ff     <= lend_in;
         lcount_ff   <= lcount_in;
         line_out_ff <= 32'(line_in);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_inside_tag       = inside_ff;
   assign rsp_tag_end          = end_ff;
   assign rsp_tag_class        = class_ff;
   assign rsp_literal_end      = lend_ff;
   assign rsp_literal_nonblank = lcount_ff;
   assign rsp_line_number      = line_out_ff;

endmodule

// ----- rtl/xed_prefix_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_prefix_classify
// narrows the candidate tag prefixes by one byte and settles the tag class
// ----------------------------------------------------------------------------
module xed_prefix_classify (
   input  logic [xed_pkg::OFFSET_BITS-1:0] offset,
   input  logic [7:0]                      data_byte,
   input  xed_pkg::prefix_type             prefix_cur,
   output xed_pkg::prefix_type             prefix_next
);

   logic [2:0]             alive;
   xed_pkg::tag_class_type cls;

   always_comb begin
      alive = prefix_cur.alive;
      cls   = prefix_cur.cls;

      if (alive[xed_pkg::CAND_COMMENT] && offset >= xed_pkg::OFFSET_FIRST &&
          offset <= xed_pkg::COMMENT_PREFIX_LEN) begin
         if (data_byte != xed_pkg::comment_char(offset)) begin
            alive[xed_pkg::CAND_COMMENT] = 1'b0;
         end else if (offset == xed_pkg::COMMENT_PREFIX_LEN) begin
            cls   = xed_pkg::CLASS_COMMENT;
            alive = '0;
         end
      end

      if (alive[xed_pkg::CAND_CDATA] && offset >= xed_pkg::OFFSET_FIRST &&
          offset <= xed_pkg::CDATA_PREFIX_LEN) begin
         if (data_byte != xed_pkg::cdata_char(offset)) begin
            alive[xed_pkg::CAND_CDATA] = 1'b0;
         end else if (offset == xed_pkg::CDATA_PREFIX_LEN) begin
            cls   = xed_pkg::CLASS_CDATA;
            alive = '0;
         end
      end

      if (alive[xed_pkg::CAND_DOCTYPE] && offset >= xed_pkg::OFFSET_FIRST) begin
         if (offset <= xed_pkg::DOCTYPE_PREFIX_LEN) begin
            if (xed_pkg::to_upper(data_byte) != xed_pkg::doctype_char(offset)) begin
               alive[xed_pkg::CAND_DOCTYPE] = 1'b0;
            end
         end else begin
            // keyword must be followed by white space or the closing bracket
            if (xed_pkg::is_c_space(data_byte) || data_byte == xed_pkg::CHAR_GT) begin
               cls = xed_pkg::CLASS_DOCTYPE;
            end
            alive = '0;
         end
      end

      if (offset >= xed_pkg::DOCTYPE_SEP_OFFSET) begin
         alive = '0;
      end

      prefix_next.alive = alive;
      prefix_next.cls   = cls;
   end

endmodule
